>>> design/uetf_pkg.sv
// Package: sizes, operation codes, entry layout, controller commands and status for the edge table.
package uetf_pkg;
   localparam int MaxEdges   = 64;
   localparam int NodeBits   = 16;
   localparam int IdxBits    = $clog2(MaxEdges);
   localparam int CntBits    = $clog2(MaxEdges + 1);
   localparam int AlphaBits  = 17;
   localparam int RateBits   = 26;
   localparam int DurBits    = 16;
   localparam int OutCntBits = 7;
   localparam int SnapLimit  = 7;
   localparam int DropLimit  = 6;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_CLEAR = 3'd1, OP_REMOVE = 3'd2, OP_FADE_NODE = 3'd3,
      OP_FADE_PAIR = 3'd4, OP_TICK = 3'd5, OP_HAS = 3'd6, OP_COUNT = 3'd7
   } op_type;

   // one table entry as stored in the entry memory
   typedef struct packed {
      logic [NodeBits-1:0]  src;
      logic [NodeBits-1:0]  tgt;
      logic                 act;
      logic [AlphaBits-1:0] alpha;
      logic [AlphaBits-1:0] goal;
      logic [RateBits-1:0]  rate;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request item
      logic scan;     // issue read of entry at scan index
      logic div_go;   // start fade-rate divider
      logic finish;   // apply add result, build response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
      logic pipe_empty;
      logic div_done;
      logic need_div;
   } stat_type;

   // saturate a count to the output width
   function automatic logic [OutCntBits-1:0] sat_cnt(input logic [CntBits-1:0] n);
      logic [31:0] w;
      w = 32'(n);
      if (w > 32'd127) return OutCntBits'(127);
      return OutCntBits'(w);
   endfunction
endpackage

>>> design/uetf_if.sv
// Valid/ready stream interfaces for request and response items.
interface uetf_req_if (input logic clock);
   logic                                    valid;
   logic                                    ready;
   logic [2:0]                              mode;
   logic [15:0]                             first_node;
   logic [15:0]                             second_node;
   logic [uetf_pkg::AlphaBits-1:0]          start_alpha;
   logic [uetf_pkg::AlphaBits-1:0]          goal_alpha;
   logic [uetf_pkg::RateBits-1:0]           fade_rate;
   logic [15:0]                             fade_duration_ms;
   logic [15:0]                             delta_ms;
   modport source (input clock, ready, output valid, mode, first_node, second_node,
                   start_alpha, goal_alpha, fade_rate, fade_duration_ms, delta_ms);
   modport sink (input clock, valid, mode, first_node, second_node, start_alpha,
                 goal_alpha, fade_rate, fade_duration_ms, delta_ms, output ready);
endinterface

interface uetf_rsp_if (input logic clock);
   logic       valid;
   logic       ready;
   logic       has_edge;
   logic [6:0] active_count;
   logic       table_full;
   logic [6:0] live_entries;
   modport source (input clock, ready,
                   output valid, has_edge, active_count, table_full, live_entries);
   modport sink (input clock, valid, has_edge, active_count, table_full, live_entries,
                 output ready);
endinterface

>>> design/uetf_div.sv
// Restoring divider: 65536000 / duration, one quotient bit per cycle.
module uetf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [uetf_pkg::DurBits-1:0]  divisor,
   output logic                          done,
   output logic [uetf_pkg::RateBits-1:0] quotient
);
   localparam int NumBits = 26;
   localparam logic [NumBits-1:0] Dividend = NumBits'(65536000);
   localparam int DurBitsP1 = uetf_pkg::DurBits + 1;

   logic [NumBits-1:0]     quo_ff, quo_in;
   logic [DurBitsP1-1:0]   rem_ff, rem_in;
   logic [4:0]             bit_ff, bit_in;
   logic                   busy_ff, busy_in;
   logic [DurBitsP1-1:0]   trial;

   // one shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DurBitsP1-2:0], Dividend[bit_ff]};
      if (start) begin
         quo_in  = '0;
         rem_in  = '0;
         bit_in  = 5'(NumBits - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         if (bit_ff == 5'd0) busy_in = 1'b0;
         else bit_in = bit_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   assign done     = !busy_ff && !start;
   assign quotient = quo_ff;
endmodule

>>> design/uetf_datapath.sv
// Datapath: entry memory, scan pipeline, per-entry update and response build.
module uetf_datapath (
   input  logic                clock,
   input  logic                reset,
   uetf_req_if.sink            req,
   input  uetf_pkg::cmd_type   cmd,
   output uetf_pkg::stat_type  stat,
   output logic                rsp_has_edge,
   output logic [6:0]          rsp_active_count,
   output logic                rsp_table_full,
   output logic [6:0]          rsp_live_entries
);
   localparam int N  = uetf_pkg::MaxEdges;
   localparam int IB = uetf_pkg::IdxBits;
   localparam int CB = uetf_pkg::CntBits;
   localparam int AB = uetf_pkg::AlphaBits;
   localparam int RB = uetf_pkg::RateBits;
   localparam int NB = uetf_pkg::NodeBits;
   // ceil(2^37 / 1000): exact floor(x / 1000) for x below 1000 * 2^17
   localparam logic [27:0] RecipMul = 28'd137438954;
   // steps at or above 2^17 exceed any alpha distance
   localparam logic [41:0] BigStep  = 42'd131072000;

   // entry storage: valid bits in flip-flops, payload in a memory
   logic [N-1:0]        valid_ff;
   uetf_pkg::entry_type entry_mem [N];

   // captured request
   uetf_pkg::op_type op_ff;
   logic [NB-1:0] n1_ff, n2_ff;
   logic [AB-1:0] start_ff, goalr_ff;
   logic [RB-1:0] rater_ff;
   logic [15:0]   dur_ff, dms_ff;

   // scan results
   logic [IB-1:0]       rd_idx_ff;
   logic                hit_ok_ff, free_ok_ff, has_ff;
   logic [IB-1:0]       hit_ff, free_ff;
   uetf_pkg::entry_type hit_ent_ff;
   logic [CB-1:0]       cnt_ff, live_ff;
   logic [RB-1:0]       frate;
   logic                div_done;

   // scan pipeline: read, multiply, divide by 1000, update
   logic                s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IB-1:0]       s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic                s1_ev_ff, s2_ev_ff, s3_ev_ff;
   uetf_pkg::entry_type rd_ent_ff, s2_ent_ff, s3_ent_ff;
   logic [41:0]         s2_prod_ff;
   logic                s3_big_ff;
   logic [AB-1:0]       s3_step_ff;

   uetf_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_go),
      .divisor(dur_ff), .done(div_done), .quotient(frate)
   );

   logic [RB-1:0] fade_rate_val;
   assign fade_rate_val = (dur_ff == 16'd0) ? RB'(65536) : frate;

   // entry in the update stage
   logic          joins, touches, fade_hit;
   logic [AB-1:0] diff;
   logic [AB-1:0] new_alpha;
   logic          drop_now, keep_now, add_new;
   always_comb begin
      joins = (s3_ent_ff.src == n1_ff && s3_ent_ff.tgt == n2_ff) ||
              (s3_ent_ff.src == n2_ff && s3_ent_ff.tgt == n1_ff);
      touches = (s3_ent_ff.src == n1_ff) || (s3_ent_ff.tgt == n1_ff);
      fade_hit = (op_ff == uetf_pkg::OP_FADE_NODE && touches) ||
                 (op_ff == uetf_pkg::OP_FADE_PAIR && joins);
      diff = (s3_ent_ff.alpha > s3_ent_ff.goal) ? s3_ent_ff.alpha - s3_ent_ff.goal
                                                : s3_ent_ff.goal - s3_ent_ff.alpha;
      if (s3_ent_ff.rate == '0 || diff < AB'(uetf_pkg::SnapLimit))
         new_alpha = s3_ent_ff.goal;
      else if (s3_big_ff || diff <= s3_step_ff) new_alpha = s3_ent_ff.goal;
      else if (s3_ent_ff.alpha < s3_ent_ff.goal) new_alpha = s3_ent_ff.alpha + s3_step_ff;
      else new_alpha = s3_ent_ff.alpha - s3_step_ff;
      drop_now = (op_ff == uetf_pkg::OP_CLEAR) ||
                 (op_ff == uetf_pkg::OP_REMOVE && touches) ||
                 (op_ff == uetf_pkg::OP_TICK && !s3_ent_ff.act &&
                  new_alpha <= AB'(uetf_pkg::DropLimit));
      keep_now = s3_ev_ff && !drop_now;
      add_new = (op_ff == uetf_pkg::OP_ADD) && !hit_ok_ff && free_ok_ff;
   end

   assign stat.scan_last  = (rd_idx_ff == IB'(N - 1));
   assign stat.pipe_empty = !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;
   assign stat.div_done   = div_done;
   assign stat.need_div   = (op_ff == uetf_pkg::OP_FADE_NODE) ||
                            (op_ff == uetf_pkg::OP_FADE_PAIR);

   // memory write port: update stage during the scan, add at finish
   logic                wr_en;
   logic [IB-1:0]       wr_idx;
   uetf_pkg::entry_type wr_ent;
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = s3_idx_ff;
      wr_ent = s3_ent_ff;
      if (s3_vld_ff && s3_ev_ff) begin
         if (fade_hit) begin
            wr_en       = 1'b1;
            wr_ent.act  = 1'b0;
            wr_ent.goal = '0;
            wr_ent.rate = fade_rate_val;
         end else if (op_ff == uetf_pkg::OP_TICK) begin
            wr_en        = 1'b1;
            wr_ent.alpha = new_alpha;
         end
      end
      if (cmd.finish && op_ff == uetf_pkg::OP_ADD) begin
         if (hit_ok_ff) begin
            wr_en       = 1'b1;
            wr_idx      = hit_ff;
            wr_ent      = hit_ent_ff;
            wr_ent.act  = 1'b1;
            wr_ent.goal = goalr_ff;
            wr_ent.rate = rater_ff;
            if (start_ff < hit_ent_ff.alpha) wr_ent.alpha = start_ff;
         end else if (free_ok_ff) begin
            wr_en        = 1'b1;
            wr_idx       = free_ff;
            wr_ent.src   = n1_ff;
            wr_ent.tgt   = n2_ff;
            wr_ent.act   = 1'b1;
            wr_ent.alpha = start_ff;
            wr_ent.goal  = goalr_ff;
            wr_ent.rate  = rater_ff;
         end
      end
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_idx] <= wr_ent;
      rd_ent_ff <= entry_mem[rd_idx_ff];
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.scan;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage data: product, then quotient by 1000
   always_ff @(posedge clock) begin
      s1_idx_ff  <= rd_idx_ff;
      s1_ev_ff   <= valid_ff[rd_idx_ff];
      s2_idx_ff  <= s1_idx_ff;
      s2_ev_ff   <= s1_ev_ff;
      s2_ent_ff  <= rd_ent_ff;
      s2_prod_ff <= 42'(rd_ent_ff.rate) * 42'(dms_ff);
      s3_idx_ff  <= s2_idx_ff;
      s3_ev_ff   <= s2_ev_ff;
      s3_ent_ff  <= s2_ent_ff;
      s3_big_ff  <= (s2_prod_ff >= BigStep);
      s3_step_ff <= AB'((55'(s2_prod_ff[26:0]) * 55'(RecipMul)) >> 37);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (s3_vld_ff && s3_ev_ff && drop_now) valid_ff[s3_idx_ff] <= 1'b0;
         if (cmd.finish && add_new) valid_ff[free_ff] <= 1'b1;
      end
   end

   // request capture and scan bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= uetf_pkg::op_type'(req.mode);
         n1_ff      <= NB'(req.first_node);
         n2_ff      <= NB'(req.second_node);
         start_ff   <= req.start_alpha;
         goalr_ff   <= req.goal_alpha;
         rater_ff   <= req.fade_rate;
         dur_ff     <= req.fade_duration_ms;
         dms_ff     <= req.delta_ms;
         rd_idx_ff  <= '0;
         hit_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
         hit_ff     <= '0;
         free_ff    <= '0;
         has_ff     <= 1'b0;
         cnt_ff     <= '0;
         live_ff    <= '0;
      end else begin
         if (cmd.scan && !stat.scan_last) rd_idx_ff <= rd_idx_ff + IB'(1);
         if (s3_vld_ff) begin
            if (keep_now) live_ff <= live_ff + CB'(1);
            if (s3_ev_ff) begin
               if (op_ff == uetf_pkg::OP_ADD && !hit_ok_ff && joins) begin
                  hit_ok_ff  <= 1'b1;
                  hit_ff     <= s3_idx_ff;
                  hit_ent_ff <= s3_ent_ff;
               end
               if (op_ff == uetf_pkg::OP_HAS && s3_ent_ff.act && joins) has_ff <= 1'b1;
               if (op_ff == uetf_pkg::OP_COUNT && s3_ent_ff.act && touches)
                  cnt_ff <= cnt_ff + CB'(1);
            end else if (!free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff    <= s3_idx_ff;
            end
         end
      end
   end

   // response fields, held from finish until taken
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_has_edge     <= (op_ff == uetf_pkg::OP_HAS) && has_ff;
         rsp_active_count <= (op_ff == uetf_pkg::OP_COUNT) ?
                             uetf_pkg::sat_cnt(cnt_ff) : 7'd0;
         rsp_table_full   <= (op_ff == uetf_pkg::OP_ADD) && !hit_ok_ff && !free_ok_ff;
         rsp_live_entries <= uetf_pkg::sat_cnt(add_new ? live_ff + CB'(1) : live_ff);
      end
   end
endmodule

>>> design/uetf_ctrl.sv
// Controller: sequences load, optional divide, table scan, drain, finish and response.
module uetf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  uetf_pkg::stat_type stat,
   output uetf_pkg::cmd_type  cmd
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_DIVGO = 7'b0000010, S_DIVW = 7'b0000100,
      S_SCAN = 7'b0001000, S_DRAIN = 7'b0010000, S_FIN = 7'b0100000,
      S_RESP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            if (stat.need_div) begin
               cmd.div_go = 1'b1;
               state_in = S_DIVW;
            end else state_in = S_SCAN;
         end
         S_DIVW: if (stat.div_done) state_in = S_SCAN;
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) state_in = S_DRAIN;
         end
         // wait for the last entries to leave the pipeline
         S_DRAIN: if (stat.pipe_empty) state_in = S_FIN;
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

>>> design/undirected_edge_table_with_fades_core.sv
// Top level of the undirected edge table with alpha fades.
// One item is worked on at a time: each request item streams every table entry, one
// per cycle, through a four-stage read/multiply/divide/update pipeline. The response
// is valid after a start state, the scan of all MaxEdges entries, a drain of the
// pipeline and a finish state. Fade-node and fade-pair items first run the fade-out
// rate divider. The next item is accepted once the response is taken; a response that
// waits holds its fields and keeps the input stalled.
module undirected_edge_table_with_fades_core (
   input logic      clock,
   input logic      reset,
   uetf_req_if.sink req,
   uetf_rsp_if.source rsp
);
   uetf_pkg::cmd_type  cmd;
   uetf_pkg::stat_type stat;

   uetf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   uetf_datapath u_dp (
      .clock(clock), .reset(reset), .req(req), .cmd(cmd), .stat(stat),
      .rsp_has_edge(rsp.has_edge), .rsp_active_count(rsp.active_count),
      .rsp_table_full(rsp.table_full), .rsp_live_entries(rsp.live_entries)
   );
endmodule
